// ===== rtl/sfwd_pkg.sv =====
// ---------------------------------------------------------------------------
// sfwd_pkg: shared types and constants of the sync-framed word deframer
// Parse phases, register indexes and the result bundle between the parser
// and the top level.
// ---------------------------------------------------------------------------
package sfwd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned WORD_W = 64;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND = 1'd1;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h55;

   typedef enum logic [2:0] {
      PH_SYNC_A = 3'd0,
      PH_SYNC_B = 3'd1,
      PH_LENGTH = 3'd2,
      PH_DATA   = 3'd3,
      PH_CHECK  = 3'd4
   } phase_type;

   // One parsed frame leaving the parser.
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] word;
   } result_type;

endpackage

// ===== rtl/sfwd_parser.sv =====
// ---------------------------------------------------------------------------
// sfwd_parser: frame hunting state machine
// Walks sync, length, payload and checksum bytes one byte at a time and
// flags a completed frame whose checksum matches.
// ---------------------------------------------------------------------------
module sfwd_parser #(
   parameter int unsigned PAYLOAD_BYTES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             byte_take,
   input  logic [sfwd_pkg::BYTE_W-1:0]      rx_byte,
   input  logic [sfwd_pkg::BYTE_W-1:0]      sync_first,
   input  logic [sfwd_pkg::BYTE_W-1:0]      sync_second,
   output sfwd_pkg::result_type             result,
   output logic                             at_check
);

   localparam int unsigned SHIFT_W = PAYLOAD_BYTES * sfwd_pkg::BYTE_W;
   localparam int unsigned CNT_W   = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(PAYLOAD_BYTES - 1);
   localparam logic [sfwd_pkg::BYTE_W-1:0] LENGTH_BYTE =
      sfwd_pkg::BYTE_W'(PAYLOAD_BYTES);

   sfwd_pkg::phase_type             phase_ff, phase_in;
   logic [SHIFT_W-1:0]              shift_ff, shift_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [sfwd_pkg::BYTE_W-1:0]     xor_ff, xor_in;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (byte_take) begin
         unique case (phase_ff)
            sfwd_pkg::PH_SYNC_B: begin
               phase_in = (rx_byte == sync_second) ? sfwd_pkg::PH_LENGTH
                                                   : sfwd_pkg::PH_SYNC_A;
            end
            sfwd_pkg::PH_LENGTH: begin
               phase_in = (rx_byte == LENGTH_BYTE) ? sfwd_pkg::PH_DATA
                                                   : sfwd_pkg::PH_SYNC_A;
            end
            sfwd_pkg::PH_DATA: begin
               phase_in = (count_ff == LAST_COUNT) ? sfwd_pkg::PH_CHECK
                                                   : sfwd_pkg::PH_DATA;
            end
            sfwd_pkg::PH_CHECK: begin
               phase_in = sfwd_pkg::PH_SYNC_A;
            end
            default: begin
               phase_in = (rx_byte == sync_first) ? sfwd_pkg::PH_SYNC_B
                                                  : sfwd_pkg::PH_SYNC_A;
            end
         endcase
      end
   end

   // Payload collection and result flag.
   always_comb begin
      shift_in     = shift_ff;
      count_in     = count_ff;
      xor_in       = xor_ff;
      result.valid = 1'b0;
      result.word  = sfwd_pkg::WORD_W'(shift_ff);
      if (byte_take) begin
         unique case (phase_ff)
            sfwd_pkg::PH_LENGTH: begin
               shift_in = '0;
               count_in = '0;
               xor_in   = '0;
            end
            sfwd_pkg::PH_DATA: begin
               // The new byte enters at the bottom and the oldest falls off the top.
               shift_in = SHIFT_W'({shift_ff, rx_byte});
               xor_in   = xor_ff ^ rx_byte;
               count_in = count_ff + CNT_W'(1);
            end
            sfwd_pkg::PH_CHECK: begin
               result.valid = (rx_byte == xor_ff);
            end
            default: begin
            end
         endcase
      end
   end

   assign at_check = (phase_ff == sfwd_pkg::PH_CHECK);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfwd_pkg::PH_SYNC_A;
         shift_ff <= '0;
         count_ff <= '0;
         xor_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
         xor_ff   <= xor_in;
      end
   end

endmodule

// ===== rtl/sync_framed_word_deframer.sv =====
// ---------------------------------------------------------------------------
// sync_framed_word_deframer: sync-word frame parser with XOR checksum
// A matching checksum byte that is accepted shows its payload on the result port
// in the next cycle, through the result register. Throughput: one byte
// per cycle while req_stall is low; the parser and its running checksum
// finish each byte in the cycle it is accepted. Reset is synchronous and
// active high: it restores the sync bytes to 0xAA and 0x55, starts the
// hunt for the first sync byte and empties the result register.
// ---------------------------------------------------------------------------
module sync_framed_word_deframer #(
   parameter int unsigned PAYLOAD_BYTES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // Received byte channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sfwd_pkg::BYTE_W-1:0]         req_rx_byte,
   // Checked payload channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sfwd_pkg::WORD_W-1:0]         rsp_payload_word,
   // Configuration writes.
   input  logic                                csr_write_enable,
   input  logic [sfwd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sfwd_pkg::BYTE_W-1:0]         csr_write_data
);

   logic [sfwd_pkg::BYTE_W-1:0]   sync_first_ff;
   logic [sfwd_pkg::BYTE_W-1:0]   sync_second_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sfwd_pkg::WORD_W-1:0]   rsp_word_ff, rsp_word_in;
   logic                          byte_take;
   logic                          at_check;
   sfwd_pkg::result_type          result;

   // Only a checksum byte can create a result, so the input is held back
   // only when the parser waits on a checksum byte and the result register
   // still holds a word the receiver has not taken. Every other byte
   // flows in while a result waits.
   assign req_stall = at_check && rsp_valid_ff && rsp_stall;
   assign byte_take = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= sfwd_pkg::SYNC_FIRST_RESET;
         sync_second_ff <= sfwd_pkg::SYNC_SECOND_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sfwd_pkg::CSR_SYNC_FIRST:  sync_first_ff  <= csr_write_data;
            sfwd_pkg::CSR_SYNC_SECOND: sync_second_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   sfwd_parser #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_take   (byte_take),
      .rx_byte     (req_rx_byte),
      .sync_first  (sync_first_ff),
      .sync_second (sync_second_ff),
      .result      (result),
      .at_check    (at_check)
   );

   // Result register: loads on a good frame, empties when the word is taken.
   // A new result can only arrive when the register is free or draining.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = result.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_word = rsp_word_ff;

endmodule
